// File: hdl/b64e_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the character table of the base64url stream encoder.
// Has no dependencies. The interfaces and every module import it.
package b64e_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned GroupWidth   = 3 * ByteWidth;
   localparam int unsigned SextetWidth  = 6;
   localparam int unsigned QueueDepthDef = 2;
   localparam logic [ByteWidth-1:0] PadReset = 8'd61;

   // Index of the final character slot of a group.
   localparam logic [1:0] SlotLast = 2'd3;

   // Last alphabet slot for each kind of group; slots above it carry the pad.
   localparam logic [1:0] SymLastOne  = 2'd1;
   localparam logic [1:0] SymLastTwo  = 2'd2;
   localparam logic [1:0] SymLastFull = 2'd3;

   typedef struct packed {
      logic [GroupWidth-1:0] word;      // bytes aligned to the top, zero filled
      logic [1:0]            sym_last;  // index of the last alphabet character
      logic                  last;      // group closes the message
   } group_type;

   typedef struct packed {
      logic [1:0] pend_cnt;
      logic       push;
   } front_status_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] slot;
   } back_status_type;

   function automatic logic [ByteWidth-1:0] b64url_char(input logic [SextetWidth-1:0] v);
      logic [ByteWidth-1:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 8'h2d;
      end else begin
         c = 8'h5f;
      end
      return c;
   endfunction

endpackage

// File: hdl/b64e_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the encoder: byte input, character output
// and the pad register write port. Depends on b64e_pkg.
interface b64e_req_if import b64e_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_rsp_if import b64e_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_char;
   logic                 last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

interface b64e_csr_if import b64e_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/b64e_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, holds the open group and pushes finished groups.
// Depends on b64e_pkg and b64e_req_if.
module b64e_front import b64e_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   b64e_req_if.sink         req,
   input  logic             q_full,
   output logic             q_push,
   output group_type        q_data,
   output front_status_type status
);

   logic [1:0]           pend_cnt_ff, pend_cnt_in;
   logic [ByteWidth-1:0] p0_ff, p0_in;
   logic [ByteWidth-1:0] p1_ff, p1_in;
   logic                 xfer;
   logic                 full_grp;

   assign req.ready = !q_full;
   assign xfer      = req.valid && req.ready;
   // A count of three cannot occur; it is handled like two held bytes.
   assign full_grp  = pend_cnt_ff[1];
   assign q_push    = xfer && (full_grp || req.last_byte);

   always_comb begin
      q_data.last = req.last_byte;
      priority if (full_grp) begin
         q_data.word     = {p0_ff, p1_ff, req.data_byte};
         q_data.sym_last = SymLastFull;
      end else if (pend_cnt_ff == 2'd0) begin
         q_data.word     = {req.data_byte, {(2*ByteWidth){1'b0}}};
         q_data.sym_last = SymLastOne;
      end else begin
         q_data.word     = {p0_ff, req.data_byte, {ByteWidth{1'b0}}};
         q_data.sym_last = SymLastTwo;
      end
   end

   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      if (xfer) begin
         if (q_push) begin
            pend_cnt_in = 2'd0;
         end else begin
            pend_cnt_in = pend_cnt_ff + 2'd1;
            if (pend_cnt_ff[0]) begin
               p1_in = req.data_byte;
            end else begin
               p0_in = req.data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
      end
      p0_ff <= p0_in;
      p1_ff <= p1_in;
   end

   assign status.pend_cnt = pend_cnt_ff;
   assign status.push     = q_push;

endmodule

// File: hdl/b64e_queue.sv
`timescale 1ns / 1ps
// Short group queue between the front end and the character serializer.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output group_type head
);

   localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

   group_type            mem [QUEUE_DEPTH];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (cnt_ff == CntWidth'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/b64e_back.sv
`timescale 1ns / 1ps
// Back end: takes one group from the queue and sends its four characters.
// Depends on b64e_pkg and b64e_rsp_if.
module b64e_back import b64e_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ByteWidth-1:0] pad_char,
   input  logic                 q_valid,
   input  group_type            q_head,
   output logic                 q_pop,
   b64e_rsp_if.source           rsp,
   output back_status_type      status
);

   group_type              grp_ff, grp_in;
   logic                   busy_ff, busy_in;
   logic [1:0]             slot_ff, slot_in;
   logic                   xfer;
   logic                   done;
   logic [SextetWidth-1:0] sextet;

   assign xfer  = rsp.valid && rsp.ready;
   assign done  = xfer && (slot_ff == SlotLast);
   // The next group is loaded in the same cycle the last character goes out.
   assign q_pop = q_valid && (!busy_ff || done);

   always_comb begin
      unique case (slot_ff)
         2'd0:    sextet = grp_ff.word[23:18];
         2'd1:    sextet = grp_ff.word[17:12];
         2'd2:    sextet = grp_ff.word[11:6];
         default: sextet = grp_ff.word[5:0];
      endcase
   end

   assign rsp.valid     = busy_ff;
   assign rsp.out_char  = (slot_ff > grp_ff.sym_last) ? pad_char : b64url_char(sextet);
   assign rsp.last_char = grp_ff.last && (slot_ff == SlotLast);

   always_comb begin
      grp_in  = grp_ff;
      busy_in = busy_ff;
      slot_in = slot_ff;
      priority if (q_pop) begin
         grp_in  = q_head;
         busy_in = 1'b1;
         slot_in = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (xfer) begin
         slot_in = slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
      grp_ff <= grp_in;
   end

   assign status.busy = busy_ff;
   assign status.slot = slot_ff;

endmodule

// File: hdl/base64url_stream_encoder_top.sv
`timescale 1ns / 1ps
// base64url stream encoder, top level. Depends on b64e_pkg, b64e_if and the
// front, queue and back modules.
// A byte is taken every cycle while the group queue has room; the byte that closes
// a group writes it into the queue, from which the serializer loads it and then
// sends one character per cycle while the output is ready, so a long message's
// rate is set by the output. Synchronous reset clears the held bytes, the
// queue and the serializer, and sets the pad character to '='.
module base64url_stream_encoder_top import b64e_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_chan,
   b64e_rsp_if.source  rsp_chan,
   b64e_csr_if.sink    csr_chan
);

   logic [ByteWidth-1:0] pad_ff, pad_in;
   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_valid;
   group_type            q_data;
   group_type            q_head;
   front_status_type     fr_stat;
   back_status_type      bk_stat;

   assign csr_chan.ready = 1'b1;
   assign pad_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= PadReset;
      end else begin
         pad_ff <= pad_in;
      end
   end

   b64e_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_data),
      .status (fr_stat)
   );

   b64e_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pad_char (pad_ff),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp      (rsp_chan),
      .status   (bk_stat)
   );

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      fr_stat.pend_cnt != 2'd3)
      else $error("held byte count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_byte) |=> fr_stat.pend_cnt == 2'd0)
      else $error("held bytes remain after the final byte");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_char) |-> (bk_stat.busy && bk_stat.slot == SlotLast))
      else $error("final character mark outside the fourth slot");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      fr_stat.push |-> !q_full)
      else $error("group pushed into a full queue");
`endif

endmodule
